FILE: src/kprg_pkg.sv
// types and constants shared by the keepalive ping rate gate
`default_nettype none

package kprg_pkg;

  localparam int unsigned NowWidth      = 48;
  localparam int unsigned IntervalWidth = 32;
  localparam int unsigned InflightWidth = 16;
  localparam int unsigned CountWidth    = 8;
  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 32;

  typedef enum logic [1:0] {
    OP_REQUEST   = 2'd0,
    OP_PING_SENT = 2'd1,
    OP_DATA_RX   = 2'd2,
    OP_RELOAD    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    VERDICT_GRANTED  = 2'd0,
    VERDICT_TOO_MANY = 2'd1,
    VERDICT_TOO_SOON = 2'd2,
    VERDICT_UPDATED  = 2'd3
  } verdict_e;

  typedef enum logic [1:0] {
    CFG_PING_BUDGET       = 2'd0,
    CFG_INFLIGHT_LIMIT    = 2'd1,
    CFG_THROTTLE_ENABLE   = 2'd2,
    CFG_THROTTLE_INTERVAL = 2'd3
  } cfg_index_e;

  localparam logic [CountWidth-1:0]    MaxPingsReset    = 8'd2;
  localparam logic [CountWidth-1:0]    MaxInflightReset = 8'd1;
  localparam logic                     ThrottleEnReset  = 1'b0;
  localparam logic [IntervalWidth-1:0] ThrottleIvReset  = 32'd60000;

  // configuration registers as seen by the front and back
  typedef struct packed {
    logic [CountWidth-1:0]    ping_budget;
    logic [CountWidth-1:0]    inflight_limit;
    logic                     throttle_enable;
    logic [IntervalWidth-1:0] throttle_interval;
  } cfg_t;

  // classified word handed from front to back
  typedef struct packed {
    op_e                      op;
    logic [NowWidth-1:0]      now;
    logic [IntervalWidth-1:0] min_interval;
    logic                     too_many_inflight;
  } cmd_t;

  // result word
  typedef struct packed {
    verdict_e                 verdict;
    logic [IntervalWidth-1:0] wait_time;
    logic [IntervalWidth-1:0] applied_interval;
    logic [NowWidth-1:0]      last_sent_time;
    logic                     last_sent_valid;
  } result_t;

endpackage

`default_nettype wire

FILE: src/keepalive_ping_rate_gate.sv
// top level of the keepalive ping rate gate
//
// decides whether a keepalive ping may go out on a link. each input word
// carries an operation: a request (checked against the in-flight limit, the
// requested minimum interval since the last ping, and the countdown of pings
// allowed without data, with an optional throttle interval once it is spent),
// a ping-sent record, a data-frame record (forgets the last ping time) or a
// countdown reload. every word yields exactly one result word, in order.
// both sides look like queues: push/full on input, empty/pop on output.
// one word per cycle sustained while the consumer keeps popping results.
// the front decodes each word and checks the in-flight limit, a short queue
// decouples it from the back, which holds the ping state and does the time
// add and compares combinationally, then a result queue decouples the consumer.
// configuration writes (cfg_ready_o is always high) should happen only while
// no word is in flight.
`default_nettype none

module keepalive_ping_rate_gate #(
  parameter int unsigned TIME_WIDTH = 48,
  parameter int unsigned CMD_DEPTH  = 2,
  parameter int unsigned RES_DEPTH  = 2
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // input side
  input  wire                                push,
  output logic                               full,
  input  wire [1:0]                          operation_i,
  input  wire [kprg_pkg::NowWidth-1:0]       now_i,
  input  wire [kprg_pkg::IntervalWidth-1:0]  min_interval_i,
  input  wire [kprg_pkg::InflightWidth-1:0]  inflight_count_i,
  // result side
  output logic                               empty,
  input  wire                                pop,
  output logic [1:0]                         verdict_o,
  output logic [kprg_pkg::IntervalWidth-1:0] wait_time_o,
  output logic [kprg_pkg::IntervalWidth-1:0] applied_interval_o,
  output logic [kprg_pkg::NowWidth-1:0]      last_sent_time_o,
  output logic                               last_sent_valid_o,
  // configuration write channel
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire [kprg_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  wire [kprg_pkg::CfgDataWidth-1:0]   cfg_data_i
);

  kprg_pkg::cfg_t    cfg_q;
  kprg_pkg::cmd_t    cmd_in, cmd_out;
  kprg_pkg::result_t res_in, res_out;
  logic              cmd_empty, cmd_pop;
  logic              res_push, res_full;
  logic              cfg_we;

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ping_budget       <= kprg_pkg::MaxPingsReset;
      cfg_q.inflight_limit    <= kprg_pkg::MaxInflightReset;
      cfg_q.throttle_enable   <= kprg_pkg::ThrottleEnReset;
      cfg_q.throttle_interval <= kprg_pkg::ThrottleIvReset;
    end else if (cfg_we) begin
      case (kprg_pkg::cfg_index_e'(cfg_index_i))
        kprg_pkg::CFG_PING_BUDGET: begin
          cfg_q.ping_budget <= cfg_data_i[kprg_pkg::CountWidth-1:0];
        end
        kprg_pkg::CFG_INFLIGHT_LIMIT: begin
          cfg_q.inflight_limit <= cfg_data_i[kprg_pkg::CountWidth-1:0];
        end
        kprg_pkg::CFG_THROTTLE_ENABLE: begin
          cfg_q.throttle_enable <= cfg_data_i[0];
        end
        kprg_pkg::CFG_THROTTLE_INTERVAL: begin
          cfg_q.throttle_interval <= cfg_data_i[kprg_pkg::IntervalWidth-1:0];
        end
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // front: decode and in-flight check
  kprg_front u_front (
    .operation_i      (operation_i),
    .now_i            (now_i),
    .min_interval_i   (min_interval_i),
    .inflight_count_i (inflight_count_i),
    .max_inflight_i   (cfg_q.inflight_limit),
    .cmd_o            (cmd_in)
  );

  // command queue between front and back
  kprg_fifo #(
    .item_t (kprg_pkg::cmd_t),
    .DEPTH  (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  // back: ping state and verdict
  kprg_back #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res_in),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  // result queue toward the consumer
  kprg_fifo #(
    .item_t (kprg_pkg::result_t),
    .DEPTH  (RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign verdict_o          = res_out.verdict;
  assign wait_time_o        = res_out.wait_time;
  assign applied_interval_o = res_out.applied_interval;
  assign last_sent_time_o   = res_out.last_sent_time;
  assign last_sent_valid_o  = res_out.last_sent_valid;

  // too soon always comes with a nonzero wait and a known last ping time
  a_too_soon_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (res_out.verdict == kprg_pkg::VERDICT_TOO_SOON)) |->
      ((wait_time_o != '0) && last_sent_valid_o))
    else $error("too soon result without wait or last ping time");

  // other verdicts carry no wait and no interval
  a_no_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (res_out.verdict != kprg_pkg::VERDICT_TOO_SOON)) |->
      ((wait_time_o == '0) && (applied_interval_o == '0)))
    else $error("wait or interval set on a result that is not too soon");

  // an accepted word is in the command queue on the next cycle
  a_cmd_queued : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> !cmd_empty)
    else $error("accepted word missing from command queue");

  // an unknown last time always reads back as zero
  a_unknown_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !last_sent_valid_o) |-> (last_sent_time_o == '0))
    else $error("last ping time nonzero while unknown");

endmodule

`default_nettype wire

FILE: src/kprg_fifo.sv
// short first-in first-out queue of words
`default_nettype none

module kprg_fifo #(
  parameter type item_t = logic,
  parameter int unsigned DEPTH = 2
) (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   push_i,
  input  item_t data_i,
  output logic  full_o,
  input  wire   pop_i,
  output item_t data_o,
  output logic  empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  item_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/kprg_front.sv
// front end: decodes the operation and pre-checks the in-flight limit
`default_nettype none

module kprg_front (
  input  wire [1:0]                          operation_i,
  input  wire [kprg_pkg::NowWidth-1:0]       now_i,
  input  wire [kprg_pkg::IntervalWidth-1:0]  min_interval_i,
  input  wire [kprg_pkg::InflightWidth-1:0]  inflight_count_i,
  input  wire [kprg_pkg::CountWidth-1:0]     max_inflight_i,
  output kprg_pkg::cmd_t                     cmd_o
);

  logic limit_on;
  logic over_limit;

  assign limit_on   = (max_inflight_i != '0);
  assign over_limit = inflight_count_i >
                      kprg_pkg::InflightWidth'(max_inflight_i);

  always_comb begin
    cmd_o.op                = kprg_pkg::op_e'(operation_i);
    cmd_o.now               = now_i;
    cmd_o.min_interval      = min_interval_i;
    // only meaningful for requests
    cmd_o.too_many_inflight = limit_on && over_limit &&
                              (kprg_pkg::op_e'(operation_i) == kprg_pkg::OP_REQUEST);
  end

endmodule

`default_nettype wire

FILE: src/kprg_back.sv
// back end: holds the ping state and produces the verdict for each command
`default_nettype none

module kprg_back #(
  parameter int unsigned TIME_WIDTH = 48
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  kprg_pkg::cfg_t     cfg_i,
  input  kprg_pkg::cmd_t     cmd_i,
  input  wire                cmd_empty_i,
  output logic               cmd_pop_o,
  output kprg_pkg::result_t  res_o,
  output logic               res_push_o,
  input  wire                res_full_i
);

  localparam int unsigned TW = TIME_WIDTH;
  localparam bit Carry64 = (TIME_WIDTH == 64);

  logic [TW-1:0]                     last_q, last_d;
  logic                              known_q, known_d;
  logic [kprg_pkg::CountWidth-1:0]   left_q, left_d;

  logic                              go;
  logic [TW-1:0]                     now_t;
  logic [TW:0]                       sum_req, sum_thr;
  logic [TW+1:0]                     diff_req, diff_thr;
  logic                              late_req, late_thr;
  logic [kprg_pkg::IntervalWidth-1:0] wait_req, wait_thr;

  assign go         = !cmd_empty_i && !res_full_i;
  assign cmd_pop_o  = go;
  assign res_push_o = go;
  assign now_t      = TW'(cmd_i.now);

  // last + interval without wrap, then compared against now
  always_comb begin
    sum_req  = {1'b0, last_q} + (TW+1)'(cmd_i.min_interval);
    sum_thr  = {1'b0, last_q} + (TW+1)'(cfg_i.throttle_interval);
    diff_req = {1'b0, sum_req} - (TW+2)'(now_t);
    diff_thr = {1'b0, sum_thr} - (TW+2)'(now_t);
    late_req = !diff_req[TW+1] && (diff_req != '0);
    late_thr = !diff_thr[TW+1] && (diff_thr != '0);
    wait_req = ((diff_req[TW+1:32] != '0) || (Carry64 && sum_req[TW])) ?
               '1 : diff_req[31:0];
    wait_thr = ((diff_thr[TW+1:32] != '0) || (Carry64 && sum_thr[TW])) ?
               '1 : diff_thr[31:0];
  end

  always_comb begin
    last_d  = last_q;
    known_d = known_q;
    left_d  = left_q;
    res_o.verdict          = kprg_pkg::VERDICT_UPDATED;
    res_o.wait_time        = '0;
    res_o.applied_interval = '0;
    case (cmd_i.op)
      kprg_pkg::OP_REQUEST: begin
        res_o.verdict = kprg_pkg::VERDICT_GRANTED;
        if (cmd_i.too_many_inflight) begin
          res_o.verdict = kprg_pkg::VERDICT_TOO_MANY;
        end else if (known_q && late_req) begin
          res_o.verdict          = kprg_pkg::VERDICT_TOO_SOON;
          res_o.wait_time        = wait_req;
          res_o.applied_interval = cmd_i.min_interval;
        end else if ((cfg_i.ping_budget != '0) && (left_q == '0)) begin
          if (cfg_i.throttle_enable) begin
            if (known_q && late_thr) begin
              res_o.verdict          = kprg_pkg::VERDICT_TOO_SOON;
              res_o.wait_time        = wait_thr;
              res_o.applied_interval = cfg_i.throttle_interval;
            end
          end else begin
            res_o.verdict = kprg_pkg::VERDICT_TOO_MANY;
          end
        end
      end
      kprg_pkg::OP_PING_SENT: begin
        last_d  = now_t;
        known_d = 1'b1;
        if (left_q != '0) begin
          left_d = left_q - 1'b1;
        end
      end
      kprg_pkg::OP_DATA_RX: begin
        last_d  = '0;
        known_d = 1'b0;
      end
      kprg_pkg::OP_RELOAD: begin
        left_d = cfg_i.ping_budget;
      end
      default: begin
        res_o.verdict = kprg_pkg::VERDICT_UPDATED;
      end
    endcase
    res_o.last_sent_time  = kprg_pkg::NowWidth'(last_d);
    res_o.last_sent_valid = known_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      known_q <= 1'b0;
      left_q  <= '0;
    end else if (go) begin
      last_q  <= last_d;
      known_q <= known_d;
      left_q  <= left_d;
    end
  end

endmodule

`default_nettype wire
